### rtl/ntla_pkg.sv
`timescale 1ns / 1ps
package ntla_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ADDR_W = 32;
  localparam int NODE_W = 8;
  localparam int UID_W = 32;
  localparam int AGE_W = 24;
  localparam int CNT_OUT_W = 5;
  localparam logic [AGE_W-1:0] AGE_RELOAD_RST = 24'd1000000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] node;
    logic [UID_W-1:0]  uid;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_DECR  = 2'd2,
    CMD_SORT  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      parity;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_FULL      = 3'd2,
    ST_ZERO      = 3'd3,
    ST_AGED      = 3'd4
  } status_t;

  typedef struct packed {
    logic walk;
    logic first;
    logic learn;
    logic addr_nz;
  } head_ctrl_t;

  typedef struct packed {
    status_t                status;
    logic [CNT_OUT_W-1:0]   valid_count;
    logic [CNT_OUT_W-1:0]   expired_count;
  } head_res_t;

  // live entries first, then expired, then empty
  function automatic logic [1:0] sort_key(entry_t e);
    logic [1:0] k;
    if (e.addr == '0) begin
      k = 2'd2;
    end else if (e.age == '0) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    return k;
  endfunction

endpackage

### rtl/ntla_cell.sv
`timescale 1ns / 1ps
module ntla_cell #(
  parameter bit POS_ODD  = 1'b0,
  parameter bit IS_FIRST = 1'b0,
  parameter bit IS_LAST  = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  ntla_pkg::cell_ctrl_t ctrl,
  input  ntla_pkg::entry_t   lower,
  input  ntla_pkg::entry_t   upper,
  output ntla_pkg::entry_t   q
);
  import ntla_pkg::*;

  entry_t q_next;
  logic   left_of_pair;
  logic   right_of_pair;

  always_comb begin
    q_next = q;
    left_of_pair = (POS_ODD == ctrl.parity) && !IS_LAST;
    right_of_pair = (POS_ODD != ctrl.parity) && !IS_FIRST;
    case (ctrl.cmd)
      CMD_SHIFT: begin
        q_next = upper;
      end
      CMD_DECR: begin
        if (q.addr != '0 && q.age != '0) begin
          q_next.age = q.age - AGE_W'(1);
        end
      end
      CMD_SORT: begin
        // odd-even transposition, swap only on strictly greater key
        if (left_of_pair && (sort_key(q) > sort_key(upper))) begin
          q_next = upper;
        end else if (right_of_pair && (sort_key(lower) > sort_key(q))) begin
          q_next = lower;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

### rtl/ntla_head.sv
`timescale 1ns / 1ps
module ntla_head #(
  parameter int TABLE_DEPTH = ntla_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ntla_pkg::head_ctrl_t ctrl,
  input  ntla_pkg::entry_t     new_entry,
  input  ntla_pkg::entry_t     e_in,
  output ntla_pkg::entry_t     e_out,
  output ntla_pkg::head_res_t  res
);
  import ntla_pkg::*;

  localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > CNT_OUT_W) ?
                         $clog2(TABLE_DEPTH + 1) : CNT_OUT_W;

  logic             done;
  logic             inserted;
  logic [CNT_W-1:0] valid_cnt;
  logic [CNT_W-1:0] expired_cnt;

  logic             done_cur;
  logic             ins_cur;
  logic [CNT_W-1:0] valid_base;
  logic [CNT_W-1:0] expired_base;
  logic             hit_empty;
  logic             hit_same;
  logic             out_valid;
  logic             out_expired;

  always_comb begin
    done_cur = ctrl.first ? 1'b0 : done;
    ins_cur = ctrl.first ? 1'b0 : inserted;
    valid_base = ctrl.first ? '0 : valid_cnt;
    expired_base = ctrl.first ? '0 : expired_cnt;
    hit_empty = ctrl.learn && ctrl.addr_nz && !done_cur && (e_in.addr == '0);
    hit_same = ctrl.learn && ctrl.addr_nz && !done_cur && (e_in.addr == new_entry.addr);
    e_out = e_in;
    if (hit_empty) begin
      e_out = new_entry;
    end else if (hit_same) begin
      e_out.age = new_entry.age;
    end
    out_valid = (e_out.addr != '0);
    out_expired = out_valid && (e_out.age == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      inserted <= 1'b0;
      valid_cnt <= '0;
      expired_cnt <= '0;
    end else if (ctrl.walk) begin
      done <= done_cur | hit_empty | hit_same;
      inserted <= ins_cur | hit_empty;
      valid_cnt <= valid_base + CNT_W'(out_valid);
      expired_cnt <= expired_base + CNT_W'(out_expired);
    end
  end

  always_comb begin
    if (!ctrl.learn) begin
      res.status = ST_AGED;
    end else if (!ctrl.addr_nz) begin
      res.status = ST_ZERO;
    end else if (done && inserted) begin
      res.status = ST_INSERTED;
    end else if (done) begin
      res.status = ST_REFRESHED;
    end else begin
      res.status = ST_FULL;
    end
    res.valid_count = valid_cnt[CNT_OUT_W-1:0];
    res.expired_count = expired_cnt[CNT_OUT_W-1:0];
  end

  a_valid_bound: assert property (@(posedge clk) disable iff (rst)
    valid_cnt <= CNT_W'(TABLE_DEPTH))
    else $error("valid count exceeds table depth");
  a_expired_le_valid: assert property (@(posedge clk) disable iff (rst)
    expired_cnt <= valid_cnt)
    else $error("expired count exceeds valid count");

endmodule

### rtl/node_table_learn_and_age.sv
`timescale 1ns / 1ps
// learn: the walk passes every slot through the head unit, then the result is registered
// age tick: decrement, TABLE_DEPTH sort rounds, then the walk
// one item at a time; the walk rotates the cell chain once through the head unit
// next input is taken as soon as the result register is loaded
// rst (synchronous) empties every slot and sets age_reload to 1000000
module node_table_learn_and_age #(
  parameter int TABLE_DEPTH = ntla_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,     // ip_addr[31:0], node_id[39:32], unique_id[71:40]
  input  logic        s_tuser,     // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // status[2:0], valid_count[7:3], expired_count[12:8]
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data  // age_reload
);
  import ntla_pkg::*;

  localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DECR = 5'b00010,
    S_SORT = 5'b00100,
    S_WALK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [AGE_W-1:0]  age_reload;
  logic              op_age;
  entry_t            new_entry;
  logic              out_load;

  cell_ctrl_t cell_ctrl;
  head_ctrl_t head_ctrl;
  head_res_t  head_res;
  entry_t     head_out;
  entry_t     cell_q [TABLE_DEPTH];

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    step_next = step;
    cell_ctrl.cmd = CMD_HOLD;
    cell_ctrl.parity = step[0];
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        if (s_tvalid) begin
          state_next = s_tuser ? S_DECR : S_WALK;
        end
      end
      S_DECR: begin
        cell_ctrl.cmd = CMD_DECR;
        state_next = S_SORT;
      end
      S_SORT: begin
        cell_ctrl.cmd = CMD_SORT;
        if (step == STEP_LAST) begin
          step_next = '0;
          state_next = S_WALK;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_WALK: begin
        cell_ctrl.cmd = CMD_SHIFT;
        if (step == STEP_LAST) begin
          step_next = '0;
          state_next = S_DONE;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    head_ctrl.walk = (state == S_WALK);
    head_ctrl.first = (state == S_WALK) && (step == '0);
    head_ctrl.learn = !op_age;
    head_ctrl.addr_nz = (new_entry.addr != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      age_reload <= AGE_RELOAD_RST;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      if (cfg_wr_en) begin
        age_reload <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_age <= s_tuser;
      new_entry.addr <= s_tdata[31:0];
      new_entry.node <= s_tdata[39:32];
      new_entry.uid <= s_tdata[71:40];
    end
    new_entry.age <= age_reload;
    if (out_load) begin
      m_tdata <= {3'b000, head_res.expired_count, head_res.valid_count, head_res.status};
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t lower;
    entry_t upper;
    if (i == 0) begin : g_lo_edge
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_q[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_up_edge
      assign upper = head_out;
    end else begin : g_up
      assign upper = cell_q[i+1];
    end
    ntla_cell #(
      .POS_ODD  (i % 2 == 1),
      .IS_FIRST (i == 0),
      .IS_LAST  (i == TABLE_DEPTH - 1)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (cell_ctrl),
      .lower (lower),
      .upper (upper),
      .q     (cell_q[i])
    );
  end

  ntla_head #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_head (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (head_ctrl),
    .new_entry (new_entry),
    .e_in      (cell_q[0]),
    .e_out     (head_out),
    .res       (head_res)
  );

  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ($past(s_tuser) ? S_DECR : S_WALK))
    else $error("transfer did not start a walk or an age tick");
  a_decr_sort: assert property (@(posedge clk) disable iff (rst)
    state == S_DECR |=> state == S_SORT && step == '0)
    else $error("decrement not followed by sort");
  a_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == S_IDLE)
    else $error("result not presented");
  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && step == STEP_LAST |=> state == S_DONE)
    else $error("walk did not end after the last slot");

endmodule

### bench/node_table_learn_and_age_tb.sv
`timescale 1ns / 1ps
module node_table_learn_and_age_tb;
  import ntla_pkg::*;

  localparam int DEPTH = 16;
  localparam int POOL_SIZE = 24;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [7:0]  node;
    logic [31:0] uid;
    logic        typed;
    head_res_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;

  logic [ADDR_W-1:0] tbl_addr [DEPTH];
  logic [NODE_W-1:0] tbl_node [DEPTH];
  logic [UID_W-1:0]  tbl_uid  [DEPTH];
  logic [AGE_W-1:0]  tbl_age  [DEPTH];
  logic [AGE_W-1:0]  reload_val;

  head_res_t pending_res [$];
  int fault_cnt = 0;
  bit calm = 1'b0;
  logic [31:0] addr_pool [POOL_SIZE];

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 32'h0000_0000, 8'h5A, 32'h1234_5678, 1'b1, '{ST_ZERO, 5'd0, 5'd0}},
    '{1'b1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_AGED, 5'd0, 5'd0}},
    '{1'b0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_INSERTED, 5'd1, 5'd0}},
    '{1'b0, 32'h0000_0001, 8'h00, 32'h0000_0000, 1'b1, '{ST_INSERTED, 5'd2, 5'd0}},
    '{1'b0, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b1, '{ST_REFRESHED, 5'd2, 5'd0}},
    '{1'b1, 32'h0000_0000, 8'h00, 32'h0000_0000, 1'b1, '{ST_AGED, 5'd2, 5'd0}},
    '{1'b0, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_ZERO, 5'd2, 5'd0}},
    '{1'b0, 32'h0A00_0001, 8'h01, 32'hA5A5_0001, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0002, 8'h02, 32'hA5A5_0002, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0003, 8'h03, 32'hA5A5_0003, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0004, 8'h04, 32'hA5A5_0004, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b1, 32'h0A00_0004, 8'h04, 32'hA5A5_0004, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0005, 8'h05, 32'hA5A5_0005, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0006, 8'h06, 32'hA5A5_0006, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0007, 8'h07, 32'hA5A5_0007, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0008, 8'h08, 32'hA5A5_0008, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_0009, 8'h09, 32'hA5A5_0009, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_000A, 8'h0A, 32'hA5A5_000A, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_000B, 8'h0B, 32'hA5A5_000B, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_000C, 8'h0C, 32'hA5A5_000C, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_000D, 8'h0D, 32'hA5A5_000D, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0A00_000E, 8'h0E, 32'hA5A5_000E, 1'b0, '{ST_INSERTED, 5'd0, 5'd0}},
    '{1'b0, 32'h0B00_0000, 8'h33, 32'h0F0F_0F0F, 1'b1, '{ST_FULL, 5'd16, 5'd0}},
    '{1'b0, 32'h0A00_0007, 8'hEE, 32'hDEAD_0007, 1'b1, '{ST_REFRESHED, 5'd16, 5'd0}}
  };

  node_table_learn_and_age dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("node_table_learn_and_age verification failed");
    $finish;
  end

  // table update for one accepted item, returns the expected status and counts
  function automatic head_res_t learn_or_age(input logic op, input logic [31:0] addr,
                                             input logic [7:0] node, input logic [31:0] uid);
    logic [ADDR_W-1:0] na [DEPTH];
    logic [NODE_W-1:0] nn [DEPTH];
    logic [UID_W-1:0]  nu [DEPTH];
    logic [AGE_W-1:0]  ng [DEPTH];
    head_res_t r;
    int n;
    int vc;
    int ec;
    bit done;
    n = 0;
    vc = 0;
    ec = 0;
    done = 1'b0;
    if (op) begin
      r.status = ST_AGED;
      for (int k = 0; k < DEPTH; k++) begin
        if (tbl_addr[k] != '0 && tbl_age[k] != '0) tbl_age[k] = tbl_age[k] - 1'b1;
        na[k] = '0;
        nn[k] = '0;
        nu[k] = '0;
        ng[k] = '0;
      end
      // live entries first, then expired ones, order kept
      for (int pass = 0; pass < 2; pass++) begin
        for (int k = 0; k < DEPTH; k++) begin
          if (tbl_addr[k] != '0 && ((tbl_age[k] == '0) == (pass == 1))) begin
            na[n] = tbl_addr[k];
            nn[n] = tbl_node[k];
            nu[n] = tbl_uid[k];
            ng[n] = tbl_age[k];
            n++;
          end
        end
      end
      for (int k = 0; k < DEPTH; k++) begin
        tbl_addr[k] = na[k];
        tbl_node[k] = nn[k];
        tbl_uid[k] = nu[k];
        tbl_age[k] = ng[k];
      end
    end else if (addr == '0) begin
      r.status = ST_ZERO;
    end else begin
      r.status = ST_FULL;
      for (int k = 0; k < DEPTH; k++) begin
        if (!done && tbl_addr[k] == '0) begin
          tbl_addr[k] = addr;
          tbl_node[k] = node;
          tbl_uid[k] = uid;
          tbl_age[k] = reload_val;
          r.status = ST_INSERTED;
          done = 1'b1;
        end else if (!done && tbl_addr[k] == addr) begin
          tbl_age[k] = reload_val;
          r.status = ST_REFRESHED;
          done = 1'b1;
        end
      end
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (tbl_addr[k] != '0) begin
        vc++;
        if (tbl_age[k] == '0) ec++;
      end
    end
    r.valid_count = vc[4:0];
    r.expired_count = ec[4:0];
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [31:0] addr, input logic [7:0] node,
                           input logic [31:0] uid, input logic typed, input head_res_t typed_res);
    int gap;
    head_res_t res;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {uid, node, addr};
    s_tuser <= op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = learn_or_age(op, addr, node, uid);
    pending_res.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int stall;
    head_res_t want;
    head_res_t got;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.status = status_t'(m_tdata[2:0]);
      got.valid_count = m_tdata[7:3];
      got.expired_count = m_tdata[12:8];
      if (pending_res.size() == 0) begin
        fault_cnt++;
        $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_res.pop_front();
        if (got.status !== want.status) begin
          fault_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.valid_count !== want.valid_count) begin
          fault_cnt++;
          $display("%0t: valid_count expected %0d actual %0d", $time,
                   want.valid_count, got.valid_count);
        end
        if (got.expired_count !== want.expired_count) begin
          fault_cnt++;
          $display("%0t: expired_count expected %0d actual %0d", $time,
                   want.expired_count, got.expired_count);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [23:0] reload_set [PHASES];
    logic op;
    logic [31:0] addr;
    int sel;
    for (int k = 0; k < DEPTH; k++) begin
      tbl_addr[k] = '0;
      tbl_node[k] = '0;
      tbl_uid[k] = '0;
      tbl_age[k] = '0;
    end
    reload_val = AGE_RELOAD_RST;
    for (int k = 0; k < 14; k++) addr_pool[k] = 32'h0A00_0001 + k;
    addr_pool[14] = 32'hFFFF_FFFF;
    addr_pool[15] = 32'h0000_0001;
    for (int k = 16; k < POOL_SIZE; k++) addr_pool[k] = {2'b11, 30'($urandom_range(1, 30'h3FFF_FFFF))};
    reload_set = '{24'd0, 24'd1, 24'd2, 24'hFF_FFFF, 24'd3, 24'd1, 24'd0, 24'd7};
    reload_set[7] = 24'($urandom_range(1, 12));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].node, dir_rows[i].uid,
                dir_rows[i].typed, dir_rows[i].res);
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= reload_set[p];
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      reload_val = reload_set[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        op = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 99);
        if (op) addr = $urandom;
        else if (sel < 5) addr = '0;
        else if (sel < 10) addr = $urandom;
        else addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_item(op, addr, 8'($urandom), $urandom, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      calm = 1'b0;
      drain_results();
    end

    if (fault_cnt == 0) begin
      $display("node_table_learn_and_age verification clean");
    end else begin
      $display("node_table_learn_and_age verification failed");
    end
    $finish;
  end

endmodule
